>>> hw/rtl/pressure_sensor_compensation_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the pressure compensation checkers.
// ============================================================================
`ifndef PRESSURE_SENSOR_COMPENSATION_MACROS_SVH
`define PRESSURE_SENSOR_COMPENSATION_MACROS_SVH

// overlapped implication, gated off during reset
`define PSC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, not gated by reset
`define PSC_ASSERT_NXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/psc_pkg.sv
// ============================================================================
// psc_pkg
// Types and constants shared by the pressure compensation datapath.
// ============================================================================
package psc_pkg;

   localparam int PSC_FIFO_DEPTH = 2;
   localparam int PSC_FIFO_PTR_W = $clog2(PSC_FIFO_DEPTH);
   localparam int PSC_FIFO_CNT_W = $clog2(PSC_FIFO_DEPTH + 1);
   localparam int PSC_DIV_STAGES = 64;
   // accept edge to the edge that samples the result strobe
   localparam int PSC_LATENCY    = 84;

   localparam logic [11:0] PSC_PRES_SCALE = 12'd3125;
   localparam logic signed [32:0] PSC_FINE_OFFSET = 33'sd128000;
   localparam logic [63:0] PSC_DIV_BIAS = 64'h0000_8000_0000_0000;

   typedef enum logic [1:0] {
      CSR_TEMP_CAL  = 2'd0,
      CSR_PRES_LOW  = 2'd1,
      CSR_PRES_HIGH = 2'd2,
      CSR_PRES_LAST = 2'd3
   } psc_csr_type;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } psc_cal_type;

   // front -> back word: temperature plus signed dividend and divisor
   typedef struct packed {
      logic [31:0] temp;
      logic [63:0] numer;
      logic [63:0] denom;
   } psc_job_type;

   // sideband carried through the divider
   typedef struct packed {
      logic [31:0] temp;
      logic        div_zero;
      logic        q_neg;
   } psc_tag_type;

endpackage

>>> hw/rtl/psc_front.sv
// ============================================================================
// psc_front
// Temperature path and pressure divisor/dividend, 11-stage pipeline.
// ============================================================================
module psc_front
   import psc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [19:0] raw_t,
   input  logic [19:0] raw_p,
   input  psc_cal_type cal,
   output logic        job_valid,
   output psc_job_type job
);

   logic [11:1] v_ff;

   // stage 1: offsets and first products
   logic signed [18:0] d_w;
   logic signed [17:0] e_w;
   logic signed [34:0] lin_full_w;
   logic signed [35:0] ee_full_w;
   logic [31:0] lprod1_ff, ee1_ff;
   logic [19:0] rawp1_ff, rawp2_ff, rawp3_ff, rawp4_ff, rawp5_ff, rawp6_ff, rawp7_ff;

   assign d_w = $signed({2'b00, raw_t[19:3]}) - $signed({2'b00, cal.t1, 1'b0});
   assign e_w = $signed({2'b00, raw_t[19:4]}) - $signed({2'b00, cal.t1});
   assign lin_full_w = d_w * $signed(cal.t2);
   assign ee_full_w  = e_w * e_w;

   // stage 2
   logic signed [31:0] qa_w;
   logic signed [47:0] qprod_full_w;
   logic [31:0] lin2_ff, qprod2_ff;

   assign qa_w = $signed(ee1_ff) >>> 12;
   assign qprod_full_w = qa_w * $signed(cal.t3);

   // stage 3
   logic [31:0] fine3_ff;

   // stage 4
   logic [31:0] f5_w;
   logic [31:0] temp4_ff, temp5_ff, temp6_ff, temp7_ff, temp8_ff, temp9_ff, temp10_ff;
   logic [31:0] temp11_ff;
   logic signed [32:0] a4_ff;

   assign f5_w = (fine3_ff << 2) + fine3_ff + 32'd128;

   // stage 5
   logic signed [65:0] aa_full_w;
   logic signed [48:0] ap5_full_w, ap2_full_w;
   logic [63:0] aa5_ff;
   logic [48:0] ap5_5_ff, ap2_5_ff, ap5_6_ff, ap2_6_ff, ap2_7_ff;

   assign aa_full_w  = a4_ff * a4_ff;
   assign ap5_full_w = a4_ff * $signed(cal.p5);
   assign ap2_full_w = a4_ff * $signed(cal.p2);

   // stage 6: split 64x16 products; upper half uses the sign-extended word
   logic signed [48:0] m6lo_w, m3lo_w;
   logic [31:0] m6hi_w, m3hi_w;
   logic [48:0] m6lo6_ff, m3lo6_ff;
   logic [31:0] m6hi6_ff, m3hi6_ff;

   assign m6lo_w = $signed({1'b0, aa5_ff[31:0]}) * $signed(cal.p6);
   assign m3lo_w = $signed({1'b0, aa5_ff[31:0]}) * $signed(cal.p3);
   assign m6hi_w = aa5_ff[63:32] * {{16{cal.p6[15]}}, cal.p6};
   assign m3hi_w = aa5_ff[63:32] * {{16{cal.p3[15]}}, cal.p3};

   // stage 7
   logic [63:0] b7_ff, x7_ff;

   // stage 8
   logic [20:0] pp_w;
   logic [63:0] a2_8_ff, pnum8_ff;

   assign pp_w = 21'h100000 - {1'b0, rawp7_ff};

   // stage 9
   logic [63:0] s9_ff;
   logic [43:0] nlo_w;
   logic [43:0] nhi_w;
   logic [43:0] nlo9_ff;
   logic [31:0] nhi9_ff;

   assign nlo_w = pnum8_ff[31:0] * PSC_PRES_SCALE;
   assign nhi_w = pnum8_ff[63:32] * PSC_PRES_SCALE;

   // stage 10
   logic [47:0] slo_w, shi_w;
   logic [47:0] slo10_ff;
   logic [31:0] shi10_ff;
   logic [63:0] numer10_ff, numer11_ff;

   assign slo_w = s9_ff[31:0] * cal.p1;
   assign shi_w = s9_ff[63:32] * cal.p1;

   // stage 11
   logic [63:0] dsum_w;
   logic [63:0] dv11_ff;

   assign dsum_w = {shi10_ff, 32'b0} + {16'b0, slo10_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[10:1], accept};
      end
   end

   always_ff @(posedge clock) begin
      lprod1_ff <= lin_full_w[31:0];
      ee1_ff    <= ee_full_w[31:0];
      rawp1_ff  <= raw_p;

      lin2_ff   <= 32'($signed(lprod1_ff) >>> 11);
      qprod2_ff <= qprod_full_w[31:0];
      rawp2_ff  <= rawp1_ff;

      fine3_ff  <= lin2_ff + 32'($signed(qprod2_ff) >>> 14);
      rawp3_ff  <= rawp2_ff;

      temp4_ff  <= 32'($signed(f5_w) >>> 8);
      a4_ff     <= $signed({fine3_ff[31], fine3_ff}) - PSC_FINE_OFFSET;
      rawp4_ff  <= rawp3_ff;

      aa5_ff    <= aa_full_w[63:0];
      ap5_5_ff  <= ap5_full_w;
      ap2_5_ff  <= ap2_full_w;
      temp5_ff  <= temp4_ff;
      rawp5_ff  <= rawp4_ff;

      m6lo6_ff  <= m6lo_w;
      m3lo6_ff  <= m3lo_w;
      m6hi6_ff  <= m6hi_w;
      m3hi6_ff  <= m3hi_w;
      ap5_6_ff  <= ap5_5_ff;
      ap2_6_ff  <= ap2_5_ff;
      temp6_ff  <= temp5_ff;
      rawp6_ff  <= rawp5_ff;

      b7_ff <= {{15{m6lo6_ff[48]}}, m6lo6_ff} + {m6hi6_ff, 32'b0}
             + ({{15{ap5_6_ff[48]}}, ap5_6_ff} << 17)
             + ({{48{cal.p4[15]}}, cal.p4} << 35);
      x7_ff    <= {{15{m3lo6_ff[48]}}, m3lo6_ff} + {m3hi6_ff, 32'b0};
      ap2_7_ff <= ap2_6_ff;
      temp7_ff <= temp6_ff;
      rawp7_ff <= rawp6_ff;

      a2_8_ff  <= 64'($signed(x7_ff) >>> 8) + ({{15{ap2_7_ff[48]}}, ap2_7_ff} << 12);
      pnum8_ff <= ({43'b0, pp_w} << 31) - b7_ff;
      temp8_ff <= temp7_ff;

      s9_ff    <= a2_8_ff + PSC_DIV_BIAS;
      nlo9_ff  <= nlo_w;
      nhi9_ff  <= nhi_w[31:0];
      temp9_ff <= temp8_ff;

      slo10_ff   <= slo_w;
      shi10_ff   <= shi_w[31:0];
      numer10_ff <= {20'b0, nlo9_ff} + {nhi9_ff, 32'b0};
      temp10_ff  <= temp9_ff;

      dv11_ff    <= 64'($signed(dsum_w) >>> 33);
      numer11_ff <= numer10_ff;
      temp11_ff  <= temp10_ff;
   end

   assign job_valid  = v_ff[11];
   assign job.temp   = temp11_ff;
   assign job.numer  = numer11_ff;
   assign job.denom  = dv11_ff;

endmodule

>>> hw/rtl/psc_fifo.sv
// ============================================================================
// psc_fifo
// Short queue of words between front and back.
// ============================================================================
module psc_fifo
   import psc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  psc_job_type push_word,
   input  logic        pop,
   output logic        not_empty,
   output logic        full,
   output psc_job_type pop_word
);

   psc_job_type               mem_ff [PSC_FIFO_DEPTH];
   logic [PSC_FIFO_PTR_W-1:0] wr_ff, rd_ff;
   logic [PSC_FIFO_CNT_W-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PSC_FIFO_PTR_W'(PSC_FIFO_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == PSC_FIFO_PTR_W'(PSC_FIFO_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + PSC_FIFO_CNT_W'(push) - PSC_FIFO_CNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_word;
      end
   end

   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == PSC_FIFO_CNT_W'(PSC_FIFO_DEPTH));
   assign pop_word  = mem_ff[rd_ff];

endmodule

>>> hw/rtl/psc_div.sv
// ============================================================================
// psc_div
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// ============================================================================
module psc_div
   import psc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [63:0] num,
   input  logic [63:0] den,
   input  psc_tag_type in_tag,
   output logic        out_valid,
   output logic [63:0] quo,
   output psc_tag_type out_tag
);

   logic        v_ff   [PSC_DIV_STAGES];
   logic [63:0] rem_ff [PSC_DIV_STAGES];
   logic [63:0] nq_ff  [PSC_DIV_STAGES];
   logic [63:0] den_ff [PSC_DIV_STAGES];
   psc_tag_type tag_ff [PSC_DIV_STAGES];

   for (genvar k = 0; k < PSC_DIV_STAGES; k++) begin : g_stage
      logic        v_i;
      logic [63:0] rem_i, nq_i, den_i;
      psc_tag_type tag_i;
      logic [64:0] trial;
      logic        ge;

      if (k == 0) begin : g_first
         assign v_i   = in_valid;
         assign rem_i = '0;
         assign nq_i  = num;
         assign den_i = den;
         assign tag_i = in_tag;
      end else begin : g_next
         assign v_i   = v_ff[k-1];
         assign rem_i = rem_ff[k-1];
         assign nq_i  = nq_ff[k-1];
         assign den_i = den_ff[k-1];
         assign tag_i = tag_ff[k-1];
      end

      assign trial = {rem_i, nq_i[63]};
      assign ge    = (trial >= {1'b0, den_i});

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_i;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= ge ? 64'(trial - {1'b0, den_i}) : trial[63:0];
         nq_ff[k]  <= {nq_i[62:0], ge};
         den_ff[k] <= den_i;
         tag_ff[k] <= tag_i;
      end
   end

   assign out_valid = v_ff[PSC_DIV_STAGES-1];
   assign quo       = nq_ff[PSC_DIV_STAGES-1];
   assign out_tag   = tag_ff[PSC_DIV_STAGES-1];

endmodule

>>> hw/rtl/psc_back.sv
// ============================================================================
// psc_back
// Pressure division and quadratic correction, drives the result word.
// ============================================================================
module psc_back
   import psc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  psc_job_type job,
   input  psc_cal_type cal,
   output logic        job_pop,
   output logic        rsp_strobe,
   output logic [31:0] rsp_temperature_centi,
   output logic [31:0] rsp_pressure_q24_8,
   output logic        rsp_pressure_valid
);

   // stage 0: signs and magnitudes
   logic        v0_ff;
   logic [63:0] nmag0_ff, dmag0_ff;
   psc_tag_type tag0_ff;

   assign job_pop = job_valid;

   always_ff @(posedge clock) begin
      nmag0_ff         <= job.numer[63] ? (~job.numer + 64'd1) : job.numer;
      dmag0_ff         <= job.denom[63] ? (~job.denom + 64'd1) : job.denom;
      tag0_ff.temp     <= job.temp;
      tag0_ff.div_zero <= (job.denom == '0);
      tag0_ff.q_neg    <= job.numer[63] ^ job.denom[63];
   end

   logic        dv_w;
   logic [63:0] quo_w;
   psc_tag_type dtag_w;

   psc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v0_ff),
      .num       (nmag0_ff),
      .den       (dmag0_ff),
      .in_tag    (tag0_ff),
      .out_valid (dv_w),
      .quo       (quo_w),
      .out_tag   (dtag_w)
   );

   logic [6:1] v_ff;
   psc_tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff, tag6_ff;
   logic [63:0] q1_ff, q2_ff, q3_ff, q4_ff, q5_ff;
   logic [63:0] ps2_ff, ps3_ff;

   // stage 2 partial products; upper half uses the sign-extended word
   logic [63:0]        ps_w;
   logic signed [48:0] m9lo_w, c8lo_w;
   logic [31:0]        m9hi_w, c8hi_w;
   logic [48:0]        m9lo2_ff, c8lo2_ff;
   logic [31:0]        m9hi2_ff, c8hi2_ff;

   assign ps_w   = 64'($signed(q1_ff) >>> 13);
   assign m9lo_w = $signed({1'b0, ps_w[31:0]}) * $signed(cal.p9);
   assign m9hi_w = ps_w[63:32] * {{16{cal.p9[15]}}, cal.p9};
   assign c8lo_w = $signed({1'b0, q1_ff[31:0]}) * $signed(cal.p8);
   assign c8hi_w = q1_ff[63:32] * {{16{cal.p8[15]}}, cal.p8};

   // stage 3
   logic [63:0] t9_3_ff, c2_3_ff, c2_4_ff, c2_5_ff;
   logic [63:0] c8sum_w;

   assign c8sum_w = {{15{c8lo2_ff[48]}}, c8lo2_ff} + {c8hi2_ff, 32'b0};

   // stage 4: 64x64 modular product from three partials
   logic [63:0] ll_w, lh_w, hl_w;
   logic [63:0] ll4_ff;
   logic [31:0] lh4_ff, hl4_ff;

   assign ll_w = t9_3_ff[31:0] * ps3_ff[31:0];
   assign lh_w = t9_3_ff[31:0] * ps3_ff[63:32];
   assign hl_w = t9_3_ff[63:32] * ps3_ff[31:0];

   // stage 5, 6, 7
   logic [31:0] lhhl_w;
   logic [63:0] c1_5_ff, s6_ff;
   logic [63:0] pq_w;

   assign lhhl_w = lh4_ff + hl4_ff;
   assign pq_w   = 64'($signed(s6_ff) >>> 8) + ({{48{cal.p7[15]}}, cal.p7} << 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff      <= 1'b0;
         v_ff       <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         v0_ff      <= job_valid;
         v_ff       <= {v_ff[5:1], dv_w};
         rsp_strobe <= v_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      q1_ff   <= dtag_w.q_neg ? (~quo_w + 64'd1) : quo_w;
      tag1_ff <= dtag_w;

      ps2_ff   <= ps_w;
      m9lo2_ff <= m9lo_w;
      m9hi2_ff <= m9hi_w;
      c8lo2_ff <= c8lo_w;
      c8hi2_ff <= c8hi_w;
      q2_ff    <= q1_ff;
      tag2_ff  <= tag1_ff;

      t9_3_ff <= {{15{m9lo2_ff[48]}}, m9lo2_ff} + {m9hi2_ff, 32'b0};
      c2_3_ff <= 64'($signed(c8sum_w) >>> 19);
      ps3_ff  <= ps2_ff;
      q3_ff   <= q2_ff;
      tag3_ff <= tag2_ff;

      ll4_ff  <= ll_w;
      lh4_ff  <= lh_w[31:0];
      hl4_ff  <= hl_w[31:0];
      c2_4_ff <= c2_3_ff;
      q4_ff   <= q3_ff;
      tag4_ff <= tag3_ff;

      c1_5_ff <= 64'($signed(ll4_ff + {lhhl_w, 32'b0}) >>> 25);
      c2_5_ff <= c2_4_ff;
      q5_ff   <= q4_ff;
      tag5_ff <= tag4_ff;

      s6_ff   <= q5_ff + c1_5_ff + c2_5_ff;
      tag6_ff <= tag5_ff;

      rsp_temperature_centi <= tag6_ff.temp;
      rsp_pressure_q24_8    <= tag6_ff.div_zero ? 32'd0 : pq_w[31:0];
      rsp_pressure_valid    <= ~tag6_ff.div_zero;
   end

endmodule

>>> hw/rtl/pressure_sensor_compensation.sv
// ============================================================================
// pressure_sensor_compensation
// Integer temperature and pressure compensation of raw converter readings.
// ============================================================================
// One word (raw temperature, raw pressure) is taken at any clock edge with
// start high and busy low, one per cycle, back to back. Each word returns
// exactly one result, in order; the result is shown for a single cycle with
// rsp_strobe high and cannot be held off. Each word passes through the front
// end (11 stages), a 2-word queue and the back end with its 64-stage
// pipelined divider. busy is high only when the queue is full. The user
// must write calibration words through the csr_ port only while no word is
// in flight; the block itself does not enforce this. A zero pressure divisor
// (P1 = 0, the reset state) yields pressure 0 with rsp_pressure_valid low,
// temperature is still computed.
module pressure_sensor_compensation
   import psc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [19:0] req_raw_temperature,
   input  logic [19:0] req_raw_pressure,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   output logic        rsp_strobe,
   output logic signed [31:0] rsp_temperature_centi,
   output logic [31:0] rsp_pressure_q24_8,
   output logic        rsp_pressure_valid
);

   // calibration registers
   logic [47:0] temp_cal_ff;
   logic [63:0] pres_low_ff, pres_high_ff;
   logic [15:0] pres_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff  <= '0;
         pres_low_ff  <= '0;
         pres_high_ff <= '0;
         pres_last_ff <= '0;
      end else if (csr_write) begin
         unique case (psc_csr_type'(csr_index))
            CSR_TEMP_CAL:  temp_cal_ff  <= csr_data[47:0];
            CSR_PRES_LOW:  pres_low_ff  <= csr_data;
            CSR_PRES_HIGH: pres_high_ff <= csr_data;
            CSR_PRES_LAST: pres_last_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   psc_cal_type cal;

   assign cal.t1 = temp_cal_ff[15:0];
   assign cal.t2 = temp_cal_ff[31:16];
   assign cal.t3 = temp_cal_ff[47:32];
   assign cal.p1 = pres_low_ff[15:0];
   assign cal.p2 = pres_low_ff[31:16];
   assign cal.p3 = pres_low_ff[47:32];
   assign cal.p4 = pres_low_ff[63:48];
   assign cal.p5 = pres_high_ff[15:0];
   assign cal.p6 = pres_high_ff[31:16];
   assign cal.p7 = pres_high_ff[47:32];
   assign cal.p8 = pres_high_ff[63:48];
   assign cal.p9 = pres_last_ff;

   logic        accept;
   logic        fjob_valid, qjob_valid, qpop, qfull;
   psc_job_type fjob, qjob;
   logic [31:0] temp_w;

   // the back end drains the queue every cycle, so it never fills in use
   assign busy   = qfull;
   assign accept = start & ~busy;

   psc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .raw_t     (req_raw_temperature),
      .raw_p     (req_raw_pressure),
      .cal       (cal),
      .job_valid (fjob_valid),
      .job       (fjob)
   );

   psc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fjob_valid),
      .push_word (fjob),
      .pop       (qpop),
      .not_empty (qjob_valid),
      .full      (qfull),
      .pop_word  (qjob)
   );

   psc_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .job_valid             (qjob_valid),
      .job                   (qjob),
      .cal                   (cal),
      .job_pop               (qpop),
      .rsp_strobe            (rsp_strobe),
      .rsp_temperature_centi (temp_w),
      .rsp_pressure_q24_8    (rsp_pressure_q24_8),
      .rsp_pressure_valid    (rsp_pressure_valid)
   );

   assign rsp_temperature_centi = $signed(temp_w);

endmodule

>>> hw/rtl/psc_checker.sv
// ============================================================================
// psc_checker
// Port-level timing checks for the pressure compensation block.
// ============================================================================
`include "pressure_sensor_compensation_macros.svh"

module psc_checker
   import psc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [31:0] rsp_pressure_q24_8,
   input logic        rsp_pressure_valid
);

   `PSC_ASSERT_NXT(a_reset_quiet, clock, reset, !rsp_strobe)
   `PSC_ASSERT_IMP(a_latency, clock, reset, start && !busy, ##PSC_LATENCY rsp_strobe)
   `PSC_ASSERT_IMP(a_zero_div, clock, reset, rsp_strobe && !rsp_pressure_valid, rsp_pressure_q24_8 == 32'd0)

endmodule

bind pressure_sensor_compensation psc_checker u_psc_checker (.*);

>>> test/pressure_sensor_compensation_checker.sv
// ============================================================================
// pressure_sensor_compensation_checker
// Watches the word and result channels of the compensation block, predicts
// each result from the calibration it has seen written, and compares in order.
// ============================================================================
module pressure_sensor_compensation_checker
   import psc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [19:0] req_raw_temperature,
   input  logic [19:0] req_raw_pressure,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        rsp_strobe,
   input  logic signed [31:0] rsp_temperature_centi,
   input  logic [31:0] rsp_pressure_q24_8,
   input  logic        rsp_pressure_valid,
   output int          mismatches,
   output int          pending,
   output int          results_seen,
   output int          invalid_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic [31:0]        pressure_q24_8;
      logic               pressure_valid;
   } compensated_type;

   logic [47:0] temp_cal;
   logic [63:0] pres_low, pres_high;
   logic [15:0] pres_last;
   compensated_type compensated_queue[$];

   function automatic logic signed [63:0] sx16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic compensated_type compensate(input logic [19:0] adc_t,
                                                  input logic [19:0] adc_p);
      logic signed [31:0] t1, t2, t3, d, e, lin, quad, fine, sq;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] a, b, dv, p, c1, c2, n, pp;
      compensated_type r;
      t1 = {16'd0, temp_cal[15:0]};
      t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
      t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
      p1 = {48'd0, pres_low[15:0]};
      p2 = sx16(pres_low[31:16]);
      p3 = sx16(pres_low[47:32]);
      p4 = sx16(pres_low[63:48]);
      p5 = sx16(pres_high[15:0]);
      p6 = sx16(pres_high[31:16]);
      p7 = sx16(pres_high[47:32]);
      p8 = sx16(pres_high[63:48]);
      p9 = sx16(pres_last);
      // temperature: every product wraps at 32 bits
      d = $signed({15'd0, adc_t[19:3]}) - 2 * t1;
      lin = (d * t2) >>> 11;
      e = $signed({16'd0, adc_t[19:4]}) - t1;
      sq = (e * e) >>> 12;
      quad = (sq * t3) >>> 14;
      fine = lin + quad;
      r.temperature_centi = (fine * 5 + 128) >>> 8;
      // pressure: 64-bit wrapping
      a = 64'(fine) - 64'sd128000;
      b = a * a * p6;
      b = b + ((a * p5) <<< 17);
      b = b + (p4 <<< 35);
      a = (((a * a) * p3) >>> 8) + ((a * p2) <<< 12);
      dv = (((64'sd1 <<< 47) + a) * p1) >>> 33;
      r.pressure_q24_8 = '0;
      r.pressure_valid = 1'b0;
      if (dv != 0) begin
         pp = 64'sd1048576 - $signed({44'd0, adc_p});
         n = ((pp <<< 31) - b) * 64'sd3125;
         if (dv == -64'sd1) p = -n;
         else p = n / dv;
         c1 = ((p9 * (p >>> 13)) * (p >>> 13)) >>> 25;
         c2 = (p8 * p) >>> 19;
         p = (((p + c1) + c2) >>> 8) + (p7 <<< 4);
         r.pressure_q24_8 = p[31:0];
         r.pressure_valid = 1'b1;
      end
      return r;
   endfunction

   assign pending = compensated_queue.size();

   always @(posedge clock) begin
      compensated_type want;
      if (reset) begin
         temp_cal <= '0; pres_low <= '0; pres_high <= '0; pres_last <= '0;
         compensated_queue.delete();
         mismatches <= 0; results_seen <= 0; invalid_seen <= 0;
      end else begin
         if (csr_write) begin
            case (psc_csr_type'(csr_index))
               CSR_TEMP_CAL:  temp_cal  <= csr_data[47:0];
               CSR_PRES_LOW:  pres_low  <= csr_data;
               CSR_PRES_HIGH: pres_high <= csr_data;
               CSR_PRES_LAST: pres_last <= csr_data[15:0];
            endcase
         end
         if (start && !busy)
            compensated_queue.push_back(compensate(req_raw_temperature, req_raw_pressure));
         if (rsp_strobe) begin
            results_seen <= results_seen + 1;
            if (!rsp_pressure_valid) invalid_seen <= invalid_seen + 1;
            if (compensated_queue.size() == 0) begin
               if (mismatches < 10) $display("unexpected result word");
               mismatches <= mismatches + 1;
            end else begin
               want = compensated_queue.pop_front();
               if (want.temperature_centi !== rsp_temperature_centi ||
                   want.pressure_q24_8 !== rsp_pressure_q24_8 ||
                   want.pressure_valid !== rsp_pressure_valid) begin
                  if (mismatches < 10)
                     $display("mismatch: exp t=%0d p=%h v=%b got t=%0d p=%h v=%b",
                        want.temperature_centi, want.pressure_q24_8,
                        want.pressure_valid, rsp_temperature_centi,
                        rsp_pressure_q24_8, rsp_pressure_valid);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end
endmodule

>>> test/pressure_sensor_compensation_test.sv
// ============================================================================
// pressure_sensor_compensation_test
// Drives raw reading words and calibration sets into the compensation block;
// the checker predicts and compares every result word.
// ============================================================================
module pressure_sensor_compensation_test
   import psc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [19:0] req_raw_temperature = '0;
   logic [19:0] req_raw_pressure = '0;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_TEMP_CAL;
   logic [63:0] csr_data = '0;
   logic        rsp_strobe;
   logic signed [31:0] rsp_temperature_centi;
   logic [31:0] rsp_pressure_q24_8;
   logic        rsp_pressure_valid;
   int mismatches, pending, results_seen, invalid_seen;
   int words_sent = 0;

   always #5 clock = ~clock;

   pressure_sensor_compensation u_dut (.*);
   pressure_sensor_compensation_checker u_checker (.*);

   // write one calibration register, idle only
   task automatic write_cal(input psc_csr_type idx, input logic [63:0] val);
      @(negedge clock);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // hold start until the word is taken; start stays high into the next word unless a gap is drawn
   task automatic send_word(input logic [19:0] t, input logic [19:0] p,
                            input bit allow_gap);
      int gap;
      if (allow_gap && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_raw_temperature <= t;
      req_raw_pressure <= p;
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // drain: wait out everything in flight, then the pipeline depth
   task automatic drain();
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (PSC_LATENCY + 4) @(negedge clock);
   endtask

   // realistic factory-style calibration with random jitter
   task automatic load_typical();
      logic [15:0] t1, t2, t3, p1;
      t1 = 16'd27504 + 16'($urandom_range(0, 2000));
      t2 = 16'd26435 + 16'($urandom_range(0, 200));
      t3 = 16'hFC18 + 16'($urandom_range(0, 200));
      p1 = 16'd36477 + 16'($urandom_range(0, 2000));
      write_cal(CSR_TEMP_CAL, {16'hDEAD, t3, t2, t1});
      write_cal(CSR_PRES_LOW, {16'd2855, 16'd3024, 16'hD64D + 16'($urandom_range(0, 50)), p1});
      write_cal(CSR_PRES_HIGH, {16'hC0EF, 16'd15500, 16'hFFF9, 16'd140});
      write_cal(CSR_PRES_LAST, {48'hBEEF, 16'd6000});
   endtask

   task automatic load_random();
      write_cal(CSR_TEMP_CAL, {$urandom, $urandom});
      write_cal(CSR_PRES_LOW, {$urandom, $urandom});
      write_cal(CSR_PRES_HIGH, {$urandom, $urandom});
      write_cal(CSR_PRES_LAST, {$urandom, $urandom});
   endtask

   task automatic load_all(input logic [63:0] v);
      write_cal(CSR_TEMP_CAL, v);
      write_cal(CSR_PRES_LOW, v);
      write_cal(CSR_PRES_HIGH, v);
      write_cal(CSR_PRES_LAST, v);
   endtask

   task automatic directed_set();
      send_word(20'h00000, 20'h00000, 0);
      send_word(20'hFFFFF, 20'hFFFFF, 0);
      send_word(20'h00000, 20'hFFFFF, 0);
      send_word(20'hFFFFF, 20'h00000, 0);
      send_word(20'h80000, 20'h65A00, 0);
      send_word(20'h7FFFF, 20'h80000, 0);
   endtask

   initial begin
      int phase, n;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset calibration: P1 zero, so pressure is flagged invalid
      directed_set();
      drain();
      // all ones, then the sign extremes
      load_all('1);
      directed_set();
      drain();
      load_all(64'h8000_8000_8000_8000);
      directed_set();
      drain();
      load_all(64'h7FFF_7FFF_7FFF_7FFF);
      directed_set();
      drain();
      // P1 one, rest zero: the divisor is 16384 for every word
      load_all('0);
      write_cal(CSR_PRES_LOW, 64'h1);
      directed_set();
      drain();
      load_typical();
      directed_set();
      send_word(20'd519888, 20'd415148, 0);
      drain();

      // random phases; last phase runs with no gaps
      for (phase = 0; phase < 10; phase++) begin
         if (phase % 3 == 2) load_random();
         else load_typical();
         for (n = 0; n < 200; n++) begin
            if ($urandom_range(0, 9) == 0)
               send_word(20'($urandom), 20'($urandom), phase != 9);
            else
               send_word(20'd400000 + 20'($urandom_range(0, 250000)),
                         20'd250000 + 20'($urandom_range(0, 300000)), phase != 9);
         end
         drain();
      end

      $display("covered %0d words over 16 calibration sets, %0d results, %0d without pressure",
               words_sent, results_seen, invalid_seen);
      if (mismatches == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end
endmodule
